/* rtl/dtjm_pkg.sv */
package dtjm_pkg;

  localparam int AXIS_W   = 8;
  localparam int SCALE_W  = 16;
  localparam int THRUST_W = 16;

  // axis * scale * 4, signed
  localparam int PROD_W = 27;
  // cruise mix product: speed (16b) * (127 +/- 2*heading) (10b)
  localparam int MIX_W  = 26;
  localparam int FAC_W  = 10;
  // quotient magnitude below the clamp point needs 21 dividend bits
  localparam int MAG_W  = 21;
  localparam int QUO_W  = 15;

  localparam int THRUST_ONE = 16384;
  localparam int SPEED_STEP = 819;
  localparam int AXIS_FULL  = 127;
  // smallest dividend magnitude whose quotient exceeds THRUST_ONE
  localparam int SAT_LIMIT  = AXIS_FULL * (THRUST_ONE + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_HALT   = 1'b1;

  typedef struct packed {
    logic                     halt;
    logic signed [AXIS_W-1:0] heading;
    logic                     accelerate;
    logic                     decelerate;
    logic                     stop_button;
  } ctl_t;

endpackage

/* rtl/dtjm_direct.sv */
module dtjm_direct (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   valid_in,
  input  logic [dtjm_pkg::SCALE_W-1:0]           scale,
  input  logic signed [dtjm_pkg::AXIS_W-1:0]     port_axis,
  input  logic signed [dtjm_pkg::AXIS_W-1:0]     starboard_axis,
  input  dtjm_pkg::ctl_t                         ctl_in,
  output logic                                   valid_out,
  output logic signed [dtjm_pkg::PROD_W-1:0]     port_prod,
  output logic signed [dtjm_pkg::PROD_W-1:0]     stbd_prod,
  output dtjm_pkg::ctl_t                         ctl_out
);

  logic signed [dtjm_pkg::PROD_W-3:0] port_mul;
  logic signed [dtjm_pkg::PROD_W-3:0] stbd_mul;

  assign port_mul = port_axis * $signed({1'b0, scale});
  assign stbd_mul = starboard_axis * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  // Q4.12 gain to Q1.14 thrust: extra factor of four
  always_ff @(posedge clk) begin
    if (adv) begin
      port_prod <= {port_mul, 2'b00};
      stbd_prod <= {stbd_mul, 2'b00};
      ctl_out   <= ctl_in;
    end
  end

endmodule

/* rtl/dtjm_cruise.sv */
module dtjm_cruise (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               valid_in,
  input  logic signed [dtjm_pkg::PROD_W-1:0] port_prod,
  input  logic signed [dtjm_pkg::PROD_W-1:0] stbd_prod,
  input  dtjm_pkg::ctl_t                     ctl,
  output logic                               valid_out,
  output logic signed [dtjm_pkg::PROD_W-1:0] port_div,
  output logic signed [dtjm_pkg::PROD_W-1:0] stbd_div,
  output logic                               cruise_out
);

  logic signed [dtjm_pkg::THRUST_W-1:0] speed;
  logic signed [dtjm_pkg::THRUST_W-1:0] speed_next;
  logic signed [dtjm_pkg::THRUST_W:0]   s_step;
  logic signed [dtjm_pkg::THRUST_W-1:0] s_clamp;
  logic signed [dtjm_pkg::THRUST_W-1:0] s_mix;
  logic signed [dtjm_pkg::FAC_W-1:0]    h_ext;
  logic signed [dtjm_pkg::FAC_W-1:0]    fac_p;
  logic signed [dtjm_pkg::FAC_W-1:0]    fac_s;
  logic signed [dtjm_pkg::MIX_W-1:0]    mix_p;
  logic signed [dtjm_pkg::MIX_W-1:0]    mix_s;
  logic                                 port_zero;
  logic                                 stbd_zero;
  logic                                 cruise;

  // |prod| / 127 truncates to zero exactly when |prod| < 127
  assign port_zero = (port_prod > -(dtjm_pkg::PROD_W)'(dtjm_pkg::AXIS_FULL)) &&
                     (port_prod <  (dtjm_pkg::PROD_W)'(dtjm_pkg::AXIS_FULL));
  assign stbd_zero = (stbd_prod > -(dtjm_pkg::PROD_W)'(dtjm_pkg::AXIS_FULL)) &&
                     (stbd_prod <  (dtjm_pkg::PROD_W)'(dtjm_pkg::AXIS_FULL));
  assign cruise    = !ctl.halt && port_zero && stbd_zero;

  always_comb begin
    priority if (ctl.decelerate) begin
      s_step = {speed[dtjm_pkg::THRUST_W-1], speed} -
               (dtjm_pkg::THRUST_W+1)'(dtjm_pkg::SPEED_STEP);
    end else if (ctl.accelerate) begin
      s_step = {speed[dtjm_pkg::THRUST_W-1], speed} +
               (dtjm_pkg::THRUST_W+1)'(dtjm_pkg::SPEED_STEP);
    end else begin
      s_step = {speed[dtjm_pkg::THRUST_W-1], speed};
    end
    priority if (s_step > (dtjm_pkg::THRUST_W+1)'(dtjm_pkg::THRUST_ONE)) begin
      s_clamp = (dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE);
    end else if (s_step < -(dtjm_pkg::THRUST_W+1)'(dtjm_pkg::THRUST_ONE)) begin
      s_clamp = -(dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE);
    end else begin
      s_clamp = s_step[dtjm_pkg::THRUST_W-1:0];
    end
  end

  // stop forces both the stored speed and the mix to zero
  assign s_mix = ctl.stop_button ? '0 : s_clamp;

  assign h_ext = {{(dtjm_pkg::FAC_W-dtjm_pkg::AXIS_W){ctl.heading[dtjm_pkg::AXIS_W-1]}},
                  ctl.heading};
  assign fac_p = (dtjm_pkg::FAC_W)'(dtjm_pkg::AXIS_FULL) + (h_ext <<< 1);
  assign fac_s = (dtjm_pkg::FAC_W)'(dtjm_pkg::AXIS_FULL) - (h_ext <<< 1);
  assign mix_p = s_mix * fac_p;
  assign mix_s = s_mix * fac_s;

  assign speed_next = cruise ? s_mix : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= '0;
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
      if (valid_in) begin
        speed <= speed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cruise_out <= cruise;
      if (ctl.halt) begin
        port_div <= '0;
        stbd_div <= '0;
      end else if (cruise) begin
        port_div <= {{(dtjm_pkg::PROD_W-dtjm_pkg::MIX_W){mix_p[dtjm_pkg::MIX_W-1]}}, mix_p};
        stbd_div <= {{(dtjm_pkg::PROD_W-dtjm_pkg::MIX_W){mix_s[dtjm_pkg::MIX_W-1]}}, mix_s};
      end else begin
        port_div <= port_prod;
        stbd_div <= stbd_prod;
      end
    end
  end

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    (speed <= (dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE)) &&
    (speed >= -(dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE)))
    else $error("cruise speed out of range");

  a_halt_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && valid_in && ctl.halt) |=> (speed == '0) && !cruise_out)
    else $error("halt did not clear speed");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && valid_in && cruise && ctl.stop_button) |=>
    (speed == '0) && (port_div == '0) && (stbd_div == '0))
    else $error("stop did not zero cruise");

endmodule

/* rtl/dtjm_div127.sv */
module dtjm_div127 (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [dtjm_pkg::PROD_W-1:0]   dividend,
  output logic signed [dtjm_pkg::THRUST_W-1:0] quotient
);

  logic                             neg;
  logic [dtjm_pkg::PROD_W-1:0]      mag;
  logic                             sat;
  logic [dtjm_pkg::QUO_W-1:0]       q0;
  logic                             a_neg;
  logic                             a_sat;
  logic [dtjm_pkg::MAG_W-1:0]       a_mlo;
  logic [dtjm_pkg::QUO_W-1:0]       a_q0;
  logic [dtjm_pkg::MAG_W:0]         q0_x127;
  logic [dtjm_pkg::MAG_W:0]         rem;
  logic [1:0]                       inc;
  logic [dtjm_pkg::QUO_W-1:0]       q;
  logic [dtjm_pkg::QUO_W-1:0]       mag_q;
  logic signed [dtjm_pkg::THRUST_W-1:0] res;

  assign neg = dividend[dtjm_pkg::PROD_W-1];
  assign mag = neg ? $unsigned(-dividend) : $unsigned(dividend);
  assign sat = mag >= (dtjm_pkg::PROD_W)'(dtjm_pkg::SAT_LIMIT);
  // 1/127 = 1/128 + 1/128^2 + ...; estimate falls short by at most three
  assign q0  = (dtjm_pkg::QUO_W)'(mag[dtjm_pkg::MAG_W-1:7]) +
               (dtjm_pkg::QUO_W)'(mag[dtjm_pkg::MAG_W-1:14]);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg <= neg;
      a_sat <= sat;
      a_mlo <= mag[dtjm_pkg::MAG_W-1:0];
      a_q0  <= q0;
    end
  end

  assign q0_x127 = {a_q0, 7'b0} - (dtjm_pkg::MAG_W+1)'(a_q0);
  assign rem     = {1'b0, a_mlo} - q0_x127;
  assign inc     = 2'(rem >= (dtjm_pkg::MAG_W+1)'(dtjm_pkg::AXIS_FULL)) +
                   2'(rem >= (dtjm_pkg::MAG_W+1)'(2 * dtjm_pkg::AXIS_FULL)) +
                   2'(rem >= (dtjm_pkg::MAG_W+1)'(3 * dtjm_pkg::AXIS_FULL));
  assign q       = a_q0 + (dtjm_pkg::QUO_W)'(inc);
  assign mag_q   = a_sat ? (dtjm_pkg::QUO_W)'(dtjm_pkg::THRUST_ONE) : q;
  assign res     = a_neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

  always_ff @(posedge clk) begin
    if (adv) begin
      quotient <= res;
    end
  end

endmodule

/* rtl/differential_thrust_joystick_mixer.sv */
// Channel   Dir  tdata (low bit up)                              tuser
// s_*       in   port_axis, starboard_axis, heading_axis,        cmd
//                accelerate, decelerate, stop_button, pad to 32
// m_*       out  port_thrust, starboard_thrust                   cruise_mode
// cfg_*     in   thrust_scale, taken on any edge with cfg_wr_en  -
//
// One transaction per cycle while the output is not stalled; a result passes
// through the input register, gain multiply, speed update and mix multiply,
// and two divide-by-127 stages. The cruise speed register closes its loop
// within one stage, so items follow each other without gaps.
// A stalled output (m_tvalid high, m_tready low) holds every stage.
// Reset clears the stage valids and the cruise speed and loads a scale of 1.0.
module differential_thrust_joystick_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // port_axis, starboard_axis, heading_axis,
                                 // accelerate, decelerate, stop_button
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // port_thrust, starboard_thrust
  output logic        m_tuser,   // cruise_mode
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                                   adv;
  logic [dtjm_pkg::SCALE_W-1:0]           scale;
  logic                                   v0;
  logic signed [dtjm_pkg::AXIS_W-1:0]     in_port;
  logic signed [dtjm_pkg::AXIS_W-1:0]     in_stbd;
  dtjm_pkg::ctl_t                         in_ctl;
  logic                                   v1;
  logic signed [dtjm_pkg::PROD_W-1:0]     port_prod;
  logic signed [dtjm_pkg::PROD_W-1:0]     stbd_prod;
  dtjm_pkg::ctl_t                         ctl1;
  logic                                   v2;
  logic signed [dtjm_pkg::PROD_W-1:0]     port_div;
  logic signed [dtjm_pkg::PROD_W-1:0]     stbd_div;
  logic                                   cruise2;
  logic                                   v3;
  logic                                   cruise3;
  logic signed [dtjm_pkg::THRUST_W-1:0]   port_q;
  logic signed [dtjm_pkg::THRUST_W-1:0]   stbd_q;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= dtjm_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v0       <= s_tvalid;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_port            <= s_tdata[7:0];
      in_stbd            <= s_tdata[15:8];
      in_ctl.heading     <= s_tdata[23:16];
      in_ctl.accelerate  <= s_tdata[24];
      in_ctl.decelerate  <= s_tdata[25];
      in_ctl.stop_button <= s_tdata[26];
      in_ctl.halt        <= (s_tuser == dtjm_pkg::CMD_HALT);
      cruise3            <= cruise2;
      m_tuser            <= cruise3;
    end
  end

  dtjm_direct u_direct (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .valid_in       (v0),
    .scale          (scale),
    .port_axis      (in_port),
    .starboard_axis (in_stbd),
    .ctl_in         (in_ctl),
    .valid_out      (v1),
    .port_prod      (port_prod),
    .stbd_prod      (stbd_prod),
    .ctl_out        (ctl1)
  );

  dtjm_cruise u_cruise (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .valid_in   (v1),
    .port_prod  (port_prod),
    .stbd_prod  (stbd_prod),
    .ctl        (ctl1),
    .valid_out  (v2),
    .port_div   (port_div),
    .stbd_div   (stbd_div),
    .cruise_out (cruise2)
  );

  dtjm_div127 u_div_port (
    .clk      (clk),
    .adv      (adv),
    .dividend (port_div),
    .quotient (port_q)
  );

  dtjm_div127 u_div_stbd (
    .clk      (clk),
    .adv      (adv),
    .dividend (stbd_div),
    .quotient (stbd_q)
  );

  assign m_tdata = {stbd_q, port_q};

  a_thrust_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
    (port_q <= (dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE)) &&
    (port_q >= -(dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE)) &&
    (stbd_q <= (dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE)) &&
    (stbd_q >= -(dtjm_pkg::THRUST_W)'(dtjm_pkg::THRUST_ONE)))
    else $error("thrust out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable({v0, v1, v2, v3}))
    else $error("pipeline moved during stall");

endmodule
